// ----- rtl/tbin_pkg.sv -----
// ----------------------------------------------------------------------------
// tbin_pkg: shared types and constants of the triangle tile binner
// Field widths, result status codes, register indexes and the job record
// that travels from the front pipeline to the emit stage.
// ----------------------------------------------------------------------------
package tbin_pkg;

   localparam int COORD_W         = 24;   // signed 16.8 vertex coordinate
   localparam int FRAC_W          = 8;    // subpixel fraction bits
   localparam int DIM_W           = 14;   // framebuffer size, tile id
   localparam int STATUS_W        = 2;
   localparam int CSR_IDX_W       = 1;
   localparam int MAX_RESULTS     = 4;    // tiles a small triangle can touch
   localparam int TILE_WIDTH_DEF  = 128;
   localparam int QUEUE_DEPTH_DEF = 4;
   localparam int FB_RESET        = 1024;

   // bin_status codes
   localparam logic [STATUS_W-1:0] ST_TILE  = 2'd0;
   localparam logic [STATUS_W-1:0] ST_CULL  = 2'd1;
   localparam logic [STATUS_W-1:0] ST_LARGE = 2'd2;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_FB_WIDTH  = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_FB_HEIGHT = 1'b1;

   typedef struct packed {
      logic [STATUS_W-1:0] kind;    // ST_TILE, ST_CULL or ST_LARGE
      logic [DIM_W-1:0]    first;   // first tile id, zero unless tile
      logic                right;   // box crosses a column boundary
      logic                down;    // box crosses a row boundary
   } job_type;

endpackage

// ----- rtl/tbin_req_if.sv -----
// ----------------------------------------------------------------------------
// tbin_req_if: triangle input channel
// Valid/ready channel carrying the three vertices of one triangle.
// ----------------------------------------------------------------------------
interface tbin_req_if;
   logic                                valid;
   logic                                ready;
   logic signed [tbin_pkg::COORD_W-1:0] v0_x;
   logic signed [tbin_pkg::COORD_W-1:0] v0_y;
   logic signed [tbin_pkg::COORD_W-1:0] v1_x;
   logic signed [tbin_pkg::COORD_W-1:0] v1_y;
   logic signed [tbin_pkg::COORD_W-1:0] v2_x;
   logic signed [tbin_pkg::COORD_W-1:0] v2_y;

   modport source (output valid, v0_x, v0_y, v1_x, v1_y, v2_x, v2_y, input ready);
   modport sink   (input valid, v0_x, v0_y, v1_x, v1_y, v2_x, v2_y, output ready);
endinterface

// ----- rtl/tbin_rsp_if.sv -----
// ----------------------------------------------------------------------------
// tbin_rsp_if: binning result channel
// Valid/ready channel carrying one tile id or one cull/large verdict.
// ----------------------------------------------------------------------------
interface tbin_rsp_if;
   logic                            valid;
   logic                            ready;
   logic [tbin_pkg::DIM_W-1:0]      tile_index;
   logic [tbin_pkg::STATUS_W-1:0]   bin_status;
   logic                            last_of_run;

   modport source (output valid, tile_index, bin_status, last_of_run, input ready);
   modport sink   (input valid, tile_index, bin_status, last_of_run, output ready);
endinterface

// ----- rtl/tbin_front.sv -----
// ----------------------------------------------------------------------------
// tbin_front: bounding box, cull, clip and tile classification
// Three-stage stallable pipeline ending in a push to the job queue. Also
// holds the framebuffer registers and the derived tiles-per-row count.
// ----------------------------------------------------------------------------
module tbin_front #(
   parameter int TILE_WIDTH = tbin_pkg::TILE_WIDTH_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_we,
   input  logic [tbin_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [tbin_pkg::DIM_W-1:0]       csr_wdata,
   tbin_req_if.sink                         req,
   output logic                             push,
   output tbin_pkg::job_type                push_job,
   input  logic                             full,
   output logic [tbin_pkg::DIM_W-1:0]       tiles_per_row
);

   localparam int CW      = tbin_pkg::COORD_W;
   localparam int DW      = tbin_pkg::DIM_W;
   localparam int FW      = tbin_pkg::FRAC_W;
   localparam int PW      = DW + FW;              // clipped subpixel coordinate
   localparam int PAD_W   = CW - PW;
   // divide by TILE_WIDTH as multiply by a rounded-up reciprocal; exact for
   // dividends below 2**DIV_W
   localparam int DIV_W   = DW + 1;
   localparam int SHIFT   = DIV_W + $clog2(TILE_WIDTH);
   localparam int RECIP_W = DIV_W + 1;
   localparam int PROD_W  = DIV_W + RECIP_W;
   localparam int RECIP   = ((1 << SHIFT) + TILE_WIDTH - 1) / TILE_WIDTH;
   localparam int TPR_RST = (tbin_pkg::FB_RESET + TILE_WIDTH - 1) / TILE_WIDTH;
   localparam logic [PW-1:0] SPAN = PW'(TILE_WIDTH << FW);

   function automatic logic [DIV_W-1:0] div_tw(input logic [DIV_W-1:0] num);
      logic [PROD_W-1:0] prod;
      prod = PROD_W'(num) * PROD_W'(RECIP);
      return DIV_W'(prod >> SHIFT);
   endfunction

   function automatic logic signed [CW-1:0] min3(input logic signed [CW-1:0] a,
                                                 input logic signed [CW-1:0] b,
                                                 input logic signed [CW-1:0] c);
      logic signed [CW-1:0] m;
      m = a;
      if (b < m) m = b;
      if (c < m) m = c;
      return m;
   endfunction

   function automatic logic signed [CW-1:0] max3(input logic signed [CW-1:0] a,
                                                 input logic signed [CW-1:0] b,
                                                 input logic signed [CW-1:0] c);
      logic signed [CW-1:0] m;
      m = a;
      if (b > m) m = b;
      if (c > m) m = c;
      return m;
   endfunction

   // ---------------- registers ----------------
   logic [DW-1:0] width_ff, width_in;
   logic [DW-1:0] height_ff, height_in;
   logic [DW-1:0] tpr_ff, tpr_in;

   logic                 a_valid_ff, a_valid_in;
   logic signed [CW-1:0] a_min_x_ff, a_min_x_in, a_max_x_ff, a_max_x_in;
   logic signed [CW-1:0] a_min_y_ff, a_min_y_in, a_max_y_ff, a_max_y_in;

   logic          b_valid_ff, b_valid_in;
   logic          b_cull_ff, b_cull_in;
   logic [PW-1:0] b_min_x_ff, b_min_x_in, b_max_x_ff, b_max_x_in;
   logic [PW-1:0] b_min_y_ff, b_min_y_in, b_max_y_ff, b_max_y_in;

   logic                             c_valid_ff, c_valid_in;
   logic [tbin_pkg::STATUS_W-1:0]    c_kind_ff, c_kind_in;
   logic [DW-1:0]                    c_fx_ff, c_fx_in, c_fy_ff, c_fy_in;
   logic [DW-1:0]                    c_lx_ff, c_lx_in, c_ly_ff, c_ly_in;

   logic                 adv;
   logic signed [CW-1:0] lim_x, lim_y;
   logic [2*DW-1:0]      row_base;
   logic [DW-1:0]        first_calc;

   assign adv           = !c_valid_ff || !full;
   assign req.ready     = adv;
   assign push          = c_valid_ff && !full;
   assign tiles_per_row = tpr_ff;

   // ---------------- registers at the csr port ----------------
   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      tpr_in    = tpr_ff;
      if (csr_we) begin
         case (csr_index)
            tbin_pkg::CSR_FB_WIDTH: begin
               width_in = csr_wdata;
               tpr_in   = DW'(div_tw(DIV_W'(csr_wdata) + DIV_W'(TILE_WIDTH - 1)));
            end
            tbin_pkg::CSR_FB_HEIGHT: begin
               height_in = csr_wdata;
            end
            default: begin
               width_in = width_ff;
            end
         endcase
      end
   end

   // ---------------- stage A: bounding box ----------------
   always_comb begin
      a_valid_in = req.valid;
      a_min_x_in = min3(req.v0_x, req.v1_x, req.v2_x);
      a_max_x_in = max3(req.v0_x, req.v1_x, req.v2_x);
      a_min_y_in = min3(req.v0_y, req.v1_y, req.v2_y);
      a_max_y_in = max3(req.v0_y, req.v1_y, req.v2_y);
   end

   // ---------------- stage B: cull and clip ----------------
   assign lim_x = signed'({PAD_W'(0), width_ff, FW'(0)});
   assign lim_y = signed'({PAD_W'(0), height_ff, FW'(0)});

   always_comb begin
      b_valid_in = a_valid_ff;
      b_cull_in  = (width_ff == '0) || (height_ff == '0) ||
                   a_max_x_ff[CW-1] || a_max_y_ff[CW-1] ||
                   (a_min_x_ff >= lim_x) || (a_min_y_ff >= lim_y);
      b_min_x_in = a_min_x_ff[CW-1] ? '0 : a_min_x_ff[PW-1:0];
      b_min_y_in = a_min_y_ff[CW-1] ? '0 : a_min_y_ff[PW-1:0];
      b_max_x_in = (a_max_x_ff >= lim_x) ? (lim_x[PW-1:0] - PW'(1)) : a_max_x_ff[PW-1:0];
      b_max_y_in = (a_max_y_ff >= lim_y) ? (lim_y[PW-1:0] - PW'(1)) : a_max_y_ff[PW-1:0];
   end

   // ---------------- stage C: size class and tile coordinates ----------------
   always_comb begin
      c_valid_in = b_valid_ff;
      if (b_cull_ff)
         c_kind_in = tbin_pkg::ST_CULL;
      else if (((b_max_x_ff - b_min_x_ff) >= SPAN) || ((b_max_y_ff - b_min_y_ff) >= SPAN))
         c_kind_in = tbin_pkg::ST_LARGE;
      else
         c_kind_in = tbin_pkg::ST_TILE;
      c_fx_in = DW'(div_tw(DIV_W'(b_min_x_ff[PW-1:FW])));
      c_fy_in = DW'(div_tw(DIV_W'(b_min_y_ff[PW-1:FW])));
      c_lx_in = DW'(div_tw(DIV_W'(b_max_x_ff[PW-1:FW])));
      c_ly_in = DW'(div_tw(DIV_W'(b_max_y_ff[PW-1:FW])));
   end

   // ---------------- push: row-major id of the first tile ----------------
   assign row_base   = {DW'(0), c_fy_ff} * {DW'(0), tpr_ff};
   assign first_calc = row_base[DW-1:0] + c_fx_ff;

   always_comb begin
      push_job.kind  = c_kind_ff;
      push_job.first = '0;
      push_job.right = 1'b0;
      push_job.down  = 1'b0;
      if (c_kind_ff == tbin_pkg::ST_TILE) begin
         push_job.first = first_calc;
         push_job.right = c_lx_ff > c_fx_ff;
         push_job.down  = c_ly_ff > c_fy_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff   <= DW'(tbin_pkg::FB_RESET);
         height_ff  <= DW'(tbin_pkg::FB_RESET);
         tpr_ff     <= DW'(TPR_RST);
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
         c_valid_ff <= 1'b0;
      end else begin
         width_ff  <= width_in;
         height_ff <= height_in;
         tpr_ff    <= tpr_in;
         if (adv) begin
            a_valid_ff <= a_valid_in;
            b_valid_ff <= b_valid_in;
            c_valid_ff <= c_valid_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         a_min_x_ff <= a_min_x_in;
         a_max_x_ff <= a_max_x_in;
         a_min_y_ff <= a_min_y_in;
         a_max_y_ff <= a_max_y_in;
         b_cull_ff  <= b_cull_in;
         b_min_x_ff <= b_min_x_in;
         b_max_x_ff <= b_max_x_in;
         b_min_y_ff <= b_min_y_in;
         b_max_y_ff <= b_max_y_in;
         c_kind_ff  <= c_kind_in;
         c_fx_ff    <= c_fx_in;
         c_fy_ff    <= c_fy_in;
         c_lx_ff    <= c_lx_in;
         c_ly_ff    <= c_ly_in;
      end
   end

endmodule

// ----- rtl/tbin_queue.sv -----
// ----------------------------------------------------------------------------
// tbin_queue: job queue between classifier and tile emitter
// Small circular buffer of job records; one push and one pop per cycle.
// ----------------------------------------------------------------------------
module tbin_queue #(
   parameter int DEPTH = tbin_pkg::QUEUE_DEPTH_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  tbin_pkg::job_type push_job,
   output logic              full,
   input  logic              pop,
   output logic              pop_valid,
   output tbin_pkg::job_type pop_job
);

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   tbin_pkg::job_type entry_ff [DEPTH];
   logic [AW-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]  count_ff, count_in;

   function automatic logic [AW-1:0] bump(input logic [AW-1:0] p);
      return (p == AW'(DEPTH - 1)) ? '0 : p + AW'(1);
   endfunction

   assign full      = count_ff == CNT_W'(DEPTH);
   assign pop_valid = count_ff != '0;
   assign pop_job   = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? bump(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = pop ? bump(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop)
         count_in = count_ff + CNT_W'(1);
      else if (pop && !push)
         count_in = count_ff - CNT_W'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

// ----- rtl/tbin_back.sv -----
// ----------------------------------------------------------------------------
// tbin_back: tile emitter
// Walks the tiles of one job (first, right, down, down-right) or its verdict,
// one result per cycle while rsp.ready allows, through a registered output.
// ----------------------------------------------------------------------------
module tbin_back (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         pop_valid,
   input  tbin_pkg::job_type            pop_job,
   output logic                         pop,
   input  logic [tbin_pkg::DIM_W-1:0]   tiles_per_row,
   tbin_rsp_if.source                   rsp
);

   localparam int DW = tbin_pkg::DIM_W;
   localparam int MR = tbin_pkg::MAX_RESULTS;

   // one bit per pending result: [0] first, [1] right, [2] down, [3] down-right
   logic [MR-1:0]                 mask_ff, mask_in;
   logic [tbin_pkg::STATUS_W-1:0] kind_ff, kind_in;
   logic [DW-1:0]                 first_ff, first_in;

   logic                          out_valid_ff, out_valid_in;
   logic [DW-1:0]                 out_tile_ff, out_tile_in;
   logic [tbin_pkg::STATUS_W-1:0] out_status_ff, out_status_in;
   logic                          out_last_ff, out_last_in;

   logic          out_free, emit, is_last;
   logic [MR-1:0] sel, rest, new_mask;
   logic [DW-1:0] tile_idx;

   assign out_free = !out_valid_ff || rsp.ready;
   assign sel      = mask_ff & (~mask_ff + MR'(1));
   assign rest     = mask_ff & ~sel;
   assign is_last  = rest == '0;
   assign emit     = (mask_ff != '0) && out_free;
   assign pop      = pop_valid && ((mask_ff == '0) || (emit && is_last));

   assign new_mask = (pop_job.kind == tbin_pkg::ST_TILE) ?
                     {pop_job.right && pop_job.down, pop_job.down, pop_job.right, 1'b1} :
                     MR'(1);

   assign tile_idx = first_ff + DW'(sel[1] || sel[3]) +
                     ((sel[2] || sel[3]) ? tiles_per_row : '0);

   always_comb begin
      mask_in  = emit ? rest : mask_ff;
      kind_in  = kind_ff;
      first_in = first_ff;
      if (pop) begin
         mask_in  = new_mask;
         kind_in  = pop_job.kind;
         first_in = pop_job.first;
      end

      out_valid_in  = out_valid_ff && !rsp.ready;
      out_tile_in   = out_tile_ff;
      out_status_in = out_status_ff;
      out_last_in   = out_last_ff;
      if (emit) begin
         out_valid_in  = 1'b1;
         out_tile_in   = tile_idx;
         out_status_in = kind_ff;
         out_last_in   = is_last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mask_ff      <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         mask_ff      <= mask_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff       <= kind_in;
      first_ff      <= first_in;
      out_tile_ff   <= out_tile_in;
      out_status_ff <= out_status_in;
      out_last_ff   <= out_last_in;
   end

   assign rsp.valid       = out_valid_ff;
   assign rsp.tile_index  = out_tile_ff;
   assign rsp.bin_status  = out_status_ff;
   assign rsp.last_of_run = out_last_ff;

endmodule

// ----- rtl/triangle_tile_binning_unit.sv -----
// ----------------------------------------------------------------------------
// triangle_tile_binning_unit: bounding-box tile binner for triangles
// Culls, clips and classifies each triangle, then emits the one to four
// tiles a small triangle touches, or one cull / large verdict.
// ----------------------------------------------------------------------------
//
//  channel  direction  handshake           payload
//  req      in         valid/ready         v0_x v0_y v1_x v1_y v2_x v2_y (s16.8)
//  rsp      out        valid/ready         tile_index bin_status last_of_run
//  csr      in         csr_we, no stall    csr_index, csr_wdata (14 bits)
//
//  The classifier is a 3-stage pipeline that takes a triangle every cycle
//  unless the job queue is full; the emitter sends one result per cycle
//  while rsp.ready allows, so a small triangle yields one to four results
//  and a culled or large one a single result, and sustained rate is set by
//  the single result port.
//  Reset: synchronous, active high; no clearing pass, ready right away.
//  Stalls: the job queue lets the classifier keep taking triangles while the
//  emitter waits on rsp.ready, until the queue and pipeline fill.
// ----------------------------------------------------------------------------
module triangle_tile_binning_unit #(
   parameter int TILE_WIDTH  = tbin_pkg::TILE_WIDTH_DEF,
   parameter int QUEUE_DEPTH = tbin_pkg::QUEUE_DEPTH_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   tbin_req_if.sink                         req,
   tbin_rsp_if.source                       rsp,
   input  logic                             csr_we,
   input  logic [tbin_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [tbin_pkg::DIM_W-1:0]       csr_wdata
);

   // front -> queue
   logic              q_push;
   tbin_pkg::job_type q_push_job;
   logic              q_full;

   // queue -> back
   logic              q_pop;
   logic              q_valid;
   tbin_pkg::job_type q_job;

   // from fb_width; only the user holds it stable while triangles are in flight
   logic [tbin_pkg::DIM_W-1:0] tiles_per_row;

   // Classifier: bounding box, cull against the framebuffer, clip to the
   // last valid subpixel, then the small/large test and tile coordinates.
   tbin_front #(
      .TILE_WIDTH (TILE_WIDTH)
   ) u_front (
      .clock         (clock),
      .reset         (reset),
      .csr_we        (csr_we),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .req           (req),
      .push          (q_push),
      .push_job      (q_push_job),
      .full          (q_full),
      .tiles_per_row (tiles_per_row)
   );

   // Job queue decouples the classifier from the result port.
   tbin_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_job  (q_push_job),
      .full      (q_full),
      .pop       (q_pop),
      .pop_valid (q_valid),
      .pop_job   (q_job)
   );

   // Emitter: one result transfer per cycle from the job at the queue head.
   tbin_back u_back (
      .clock         (clock),
      .reset         (reset),
      .pop_valid     (q_valid),
      .pop_job       (q_job),
      .pop           (q_pop),
      .tiles_per_row (tiles_per_row),
      .rsp           (rsp)
   );

   // ---------------- assertions ----------------

   // cull and large verdicts are single results with a zero tile id
   assert property (@(posedge clock) disable iff (reset)
      (rsp.valid && rsp.bin_status != tbin_pkg::ST_TILE) |->
         (rsp.last_of_run && rsp.tile_index == '0))
      else $error("verdict result without last flag or with tile id");

   // classifier never writes into a full queue
   assert property (@(posedge clock) disable iff (reset)
      q_push |-> !q_full)
      else $error("job queue overflow");

   // emitter only takes a job that is there
   assert property (@(posedge clock) disable iff (reset)
      q_pop |-> q_valid)
      else $error("job queue underflow");

   // no result is offered right after reset
   assert property (@(posedge clock)
      reset |=> !rsp.valid)
      else $error("result valid after reset");

endmodule

// ----- tb/triangle_tile_binning_unit_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// triangle_tile_binning_unit_tb: self-checking bench for the tile binner
// Feeds triangles through the req channel from a queue, predicts the cull /
// large / tile results of each transfer against a mirror of the framebuffer
// size registers, and checks every rsp transfer in order. Both channels idle
// in random bursts; the size registers change between drained phases.
// ----------------------------------------------------------------------------
module triangle_tile_binning_unit_tb;

   localparam int COORD_W     = tbin_pkg::COORD_W;
   localparam int FRAC_W      = tbin_pkg::FRAC_W;
   localparam int DIM_W       = tbin_pkg::DIM_W;
   localparam int STATUS_W    = tbin_pkg::STATUS_W;
   localparam int CSR_IDX_W   = tbin_pkg::CSR_IDX_W;
   localparam int FB_RESET    = tbin_pkg::FB_RESET;
   localparam int PX          = 1 << FRAC_W;          // one pixel in subpixels
   localparam int TILE_W      = tbin_pkg::TILE_WIDTH_DEF; // dut runs at its default
   localparam int SPAN        = TILE_W * PX;          // one tile in subpixels
   localparam int CMIN        = -(1 << (COORD_W - 1));
   localparam int CMAX        = (1 << (COORD_W - 1)) - 1;
   localparam int SIZE_MASK   = (1 << DIM_W) - 1;
   localparam int DRAIN_CYC   = 16;                   // dut pipeline plus margin
   localparam int MISSING_CYC = 2000;

   typedef struct packed {
      logic signed [COORD_W-1:0] v0_x;
      logic signed [COORD_W-1:0] v0_y;
      logic signed [COORD_W-1:0] v1_x;
      logic signed [COORD_W-1:0] v1_y;
      logic signed [COORD_W-1:0] v2_x;
      logic signed [COORD_W-1:0] v2_y;
   } triangle_type;

   typedef struct {
      logic [DIM_W-1:0]    tile_index;
      logic [STATUS_W-1:0] status;
      logic                last_of_run;
   } bin_result_type;

   logic                 clock;
   logic                 reset;
   logic                 csr_we;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [DIM_W-1:0]     csr_wdata;

   tbin_req_if req_bus ();
   tbin_rsp_if rsp_bus ();

   triangle_tile_binning_unit dut (
      .clock     (clock),
      .reset     (reset),
      .req       (req_bus),
      .rsp       (rsp_bus),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // Mirror of the size registers, kept in step with every csr write.
   int fb_w;
   int fb_h;

   triangle_type   pending_tris[$];    // waiting for the driver
   triangle_type   tri_on_bus;         // payload currently offered on req
   bin_result_type expected_bins[$];   // predicted rsp transfers, oldest first

   int src_idle_odds;   // percent chance per free slot to start a req gap
   int snk_idle_odds;   // percent chance per cycle to start an rsp stall
   int src_gap;
   int snk_stall;
   int mismatch_count;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Hard stop in case the dut hangs on either channel.
   initial begin
      #2_000_000;
      $display("timeout: req pending %0d, rsp expected %0d",
               pending_tris.size(), expected_bins.size());
      $display("** triangle_tile_binning_unit: FAILED **");
      $finish;
   end

   task automatic flag_mismatch(input string msg);
      mismatch_count++;
      $display("%0t: MISMATCH %s", $time, msg);
   endtask

   // Bin predictor: bounding box, cull, clip, classify, then the tile walk
   // first / right / down / down-right for a small triangle.
   function automatic void bin_triangle(triangle_type t);
      int xs[3];
      int ys[3];
      int lo_x, hi_x, lo_y, hi_y;
      int lim_x, lim_y, per_row, fx, fy;
      bit right, down;
      logic [DIM_W-1:0] first;
      logic [DIM_W-1:0] ids[$];
      xs[0] = int'(t.v0_x);  ys[0] = int'(t.v0_y);
      xs[1] = int'(t.v1_x);  ys[1] = int'(t.v1_y);
      xs[2] = int'(t.v2_x);  ys[2] = int'(t.v2_y);
      lo_x = xs[0];  hi_x = xs[0];
      lo_y = ys[0];  hi_y = ys[0];
      for (int i = 1; i < 3; i++) begin
         if (xs[i] < lo_x) lo_x = xs[i];
         if (xs[i] > hi_x) hi_x = xs[i];
         if (ys[i] < lo_y) lo_y = ys[i];
         if (ys[i] > hi_y) hi_y = ys[i];
      end
      lim_x = fb_w << FRAC_W;
      lim_y = fb_h << FRAC_W;

      // a zero-sized framebuffer culls everything
      if (fb_w == 0 || fb_h == 0 || hi_x < 0 || hi_y < 0 ||
          lo_x >= lim_x || lo_y >= lim_y) begin
         expected_bins.push_back('{tile_index: '0, status: tbin_pkg::ST_CULL,
                                   last_of_run: 1'b1});
         return;
      end

      // clip to the last valid subpixel
      if (lo_x < 0) lo_x = 0;
      if (lo_y < 0) lo_y = 0;
      if (hi_x >= lim_x) hi_x = lim_x - 1;
      if (hi_y >= lim_y) hi_y = lim_y - 1;

      if (hi_x - lo_x >= SPAN || hi_y - lo_y >= SPAN) begin
         expected_bins.push_back('{tile_index: '0, status: tbin_pkg::ST_LARGE,
                                   last_of_run: 1'b1});
         return;
      end

      per_row = (fb_w + TILE_W - 1) / TILE_W;
      fx      = (lo_x >> FRAC_W) / TILE_W;
      fy      = (lo_y >> FRAC_W) / TILE_W;
      right   = ((hi_x >> FRAC_W) / TILE_W) > fx;
      down    = ((hi_y >> FRAC_W) / TILE_W) > fy;
      first   = DIM_W'(fy * per_row + fx);      // ids wrap at DIM_W bits

      ids.push_back(first);
      if (right)         ids.push_back(DIM_W'(first + 1));
      if (down)          ids.push_back(DIM_W'(first + per_row));
      if (right && down) ids.push_back(DIM_W'(first + 1 + per_row));
      foreach (ids[i])
         expected_bins.push_back('{tile_index: ids[i], status: tbin_pkg::ST_TILE,
                                   last_of_run: (i == ids.size() - 1)});
   endfunction

   // ------------------------------------------------------------------------
   // req driver: one triangle per transfer from pending_tris. The prediction
   // is made at the edge of the transfer, so it always sees the register
   // mirror that the dut sees. A new item or a gap is chosen only when the
   // current one has gone (or nothing is offered).
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      if (!reset) begin
         if (req_bus.valid && req_bus.ready)
            bin_triangle(tri_on_bus);
         if (!req_bus.valid || req_bus.ready) begin
            if (src_gap > 0) begin
               src_gap--;
               req_bus.valid <= 1'b0;
            end else if (pending_tris.size() != 0 &&
                         $urandom_range(0, 99) < src_idle_odds) begin
               // start a gap burst
               src_gap = $urandom_range(0, 4);
               req_bus.valid <= 1'b0;
            end else if (pending_tris.size() != 0) begin
               tri_on_bus = pending_tris.pop_front();
               req_bus.v0_x  <= tri_on_bus.v0_x;
               req_bus.v0_y  <= tri_on_bus.v0_y;
               req_bus.v1_x  <= tri_on_bus.v1_x;
               req_bus.v1_y  <= tri_on_bus.v1_y;
               req_bus.v2_x  <= tri_on_bus.v2_x;
               req_bus.v2_y  <= tri_on_bus.v2_y;
               req_bus.valid <= 1'b1;
            end else begin
               req_bus.valid <= 1'b0;
            end
         end
      end
   end

   // ------------------------------------------------------------------------
   // rsp monitor: every transfer is matched against the oldest prediction,
   // field by field. ready drops in random stall bursts.
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (expected_bins.size() == 0) begin
               flag_mismatch($sformatf("unexpected result tile %0d status %0d last %0b",
                                       rsp_bus.tile_index, rsp_bus.bin_status,
                                       rsp_bus.last_of_run));
            end else begin
               if (rsp_bus.tile_index !== expected_bins[0].tile_index)
                  flag_mismatch($sformatf("tile_index %0d, expected %0d",
                                          rsp_bus.tile_index,
                                          expected_bins[0].tile_index));
               if (rsp_bus.bin_status !== expected_bins[0].status)
                  flag_mismatch($sformatf("bin_status %0d, expected %0d",
                                          rsp_bus.bin_status, expected_bins[0].status));
               if (rsp_bus.last_of_run !== expected_bins[0].last_of_run)
                  flag_mismatch($sformatf("last_of_run %0b, expected %0b",
                                          rsp_bus.last_of_run,
                                          expected_bins[0].last_of_run));
               void'(expected_bins.pop_front());
            end
         end
         if (snk_stall > 0) begin
            snk_stall--;
            rsp_bus.ready <= 1'b0;
         end else if ($urandom_range(0, 99) < snk_idle_odds) begin
            snk_stall = $urandom_range(0, 4);
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= 1'b1;
         end
      end
   end

   function automatic void queue_triangle(int x0, int y0, int x1, int y1, int x2, int y2);
      triangle_type t;
      t.v0_x = x0[COORD_W-1:0];  t.v0_y = y0[COORD_W-1:0];
      t.v1_x = x1[COORD_W-1:0];  t.v1_y = y1[COORD_W-1:0];
      t.v2_x = x2[COORD_W-1:0];  t.v2_y = y2[COORD_W-1:0];
      pending_tris.push_back(t);
   endfunction

   // Mostly boxes near the framebuffer with a spread of up to one tile, so the
   // tile walk is exercised; some wider boxes; some raw 24-bit noise.
   function automatic triangle_type random_triangle();
      triangle_type t;
      int pick, reach, cx, cy;
      pick = $urandom_range(0, 9);
      if (pick < 2) begin
         t.v0_x = COORD_W'($urandom);  t.v0_y = COORD_W'($urandom);
         t.v1_x = COORD_W'($urandom);  t.v1_y = COORD_W'($urandom);
         t.v2_x = COORD_W'($urandom);  t.v2_y = COORD_W'($urandom);
         return t;
      end
      reach = (pick < 8) ? $urandom_range(0, SPAN) : $urandom_range(SPAN / 2, 3 * SPAN);
      cx = int'($urandom_range(0, (fb_w << FRAC_W) + 2 * SPAN)) - SPAN;
      cy = int'($urandom_range(0, (fb_h << FRAC_W) + 2 * SPAN)) - SPAN;
      t.v0_x = COORD_W'(cx + int'($urandom_range(0, reach)));
      t.v0_y = COORD_W'(cy + int'($urandom_range(0, reach)));
      t.v1_x = COORD_W'(cx + int'($urandom_range(0, reach)));
      t.v1_y = COORD_W'(cy + int'($urandom_range(0, reach)));
      t.v2_x = COORD_W'(cx + int'($urandom_range(0, reach)));
      t.v2_y = COORD_W'(cy + int'($urandom_range(0, reach)));
      return t;
   endfunction

   task automatic queue_random(input int count);
      repeat (count) pending_tris.push_back(random_triangle());
   endtask

   // Register writes happen only here, and only once the dut is drained.
   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input int value);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= DIM_W'(value);
      @(posedge clock);
      csr_we    <= 1'b0;
      if (idx == tbin_pkg::CSR_FB_WIDTH)
         fb_w = value & SIZE_MASK;
      else
         fb_h = value & SIZE_MASK;
   endtask

   task automatic set_framebuffer(input int w, input int h);
      write_csr(tbin_pkg::CSR_FB_WIDTH, w);
      write_csr(tbin_pkg::CSR_FB_HEIGHT, h);
   endtask

   // Sampled at the falling edge, clear of the driver's and monitor's updates.
   task automatic wait_drained();
      int spins = 0;
      do @(negedge clock); while (pending_tris.size() != 0 || req_bus.valid);
      while (expected_bins.size() != 0 && spins < MISSING_CYC) begin
         @(negedge clock);
         spins++;
      end
      if (expected_bins.size() != 0) begin
         flag_mismatch($sformatf("%0d expected results never arrived",
                                 expected_bins.size()));
         expected_bins.delete();
      end
      repeat (DRAIN_CYC) @(negedge clock);
   endtask

   initial begin
      reset          = 1'b1;
      csr_we         = 1'b0;
      csr_index      = '0;
      csr_wdata      = '0;
      req_bus.valid  = 1'b0;
      req_bus.v0_x   = '0;
      req_bus.v0_y   = '0;
      req_bus.v1_x   = '0;
      req_bus.v1_y   = '0;
      req_bus.v2_x   = '0;
      req_bus.v2_y   = '0;
      rsp_bus.ready  = 1'b1;
      fb_w           = FB_RESET;
      fb_h           = FB_RESET;
      src_gap        = 0;
      snk_stall      = 0;
      mismatch_count = 0;
      src_idle_odds  = 20;
      snk_idle_odds  = 20;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // ---- directed, reset sizes 1024 x 1024 (8 x 8 tiles) ----
      queue_triangle(10*PX, 10*PX, 20*PX, 10*PX, 10*PX, 20*PX);       // one tile
      queue_triangle(120*PX, 10*PX, 130*PX, 15*PX, 125*PX, 20*PX);    // + right
      queue_triangle(10*PX, 120*PX, 15*PX, 130*PX, 20*PX, 125*PX);    // + down
      queue_triangle(130*PX, 120*PX, 120*PX, 130*PX, 125*PX, 125*PX); // all four
      queue_triangle(128*PX-1, 10*PX, 128*PX, 10*PX, 128*PX, 10*PX);  // 1-subpixel cross
      queue_triangle(128*PX, 128*PX, 128*PX, 128*PX, 128*PX, 128*PX); // point on corner
      queue_triangle(1000*PX, 1000*PX, 1024*PX-1, 1010*PX, 1010*PX, 1024*PX-1);
      queue_triangle(CMIN, 5*PX, 5*PX, CMIN, 3*PX, 3*PX);             // clip low
      queue_triangle(1020*PX, 1020*PX, CMAX, 1021*PX, 1021*PX, CMAX); // clip high
      queue_triangle(-PX, 0, -1, 100*PX, -50*PX, 50*PX);              // max_x = -1: cull
      queue_triangle(0, 0, -5*PX, 3*PX, -1, 6*PX);                    // max_x = 0: kept
      queue_triangle(5*PX, -1, 50*PX, -PX, 8*PX, -300*PX);            // max_y < 0: cull
      queue_triangle(1024*PX, 5*PX, 1100*PX, 6*PX, 2000*PX, 7*PX);    // min_x at limit
      queue_triangle(1024*PX-1, 5*PX, 1030*PX, 6*PX, 1024*PX, 7*PX);  // just inside
      queue_triangle(5*PX, 1024*PX, 6*PX, 1030*PX, 7*PX, 1500*PX);    // min_y at limit
      queue_triangle(0, 0, 128*PX, 0, 5*PX, 5*PX);                    // span = tile: large
      queue_triangle(64*PX, 0, 192*PX-1, 5*PX, 70*PX, 3*PX);          // span = tile - 1
      queue_triangle(5*PX, 100*PX, 6*PX, 228*PX, 7*PX, 150*PX);       // large in y only
      queue_triangle(CMIN, CMIN, CMIN, CMIN, CMIN, CMIN);
      queue_triangle(CMAX, CMAX, CMAX, CMAX, CMAX, CMAX);
      queue_triangle(CMIN, CMIN, CMAX, CMAX, 0, 0);                   // clipped to full frame
      wait_drained();

      // heavy rsp back-pressure so the job queue fills
      snk_idle_odds = 50;
      queue_random(60);
      wait_drained();

      // ---- largest framebuffer: tile ids reach the top of the range ----
      src_idle_odds = 15;
      snk_idle_odds = 15;
      set_framebuffer(SIZE_MASK, SIZE_MASK);
      queue_triangle(16380*PX, 16380*PX, 16383*PX-1, 16381*PX, 16381*PX, 16383*PX-1);
      queue_triangle(16250*PX, 16250*PX, 16260*PX, 16260*PX, 16255*PX, 16252*PX);
      queue_triangle(CMIN, CMIN, CMAX, CMAX, 0, 0);
      queue_random(40);
      wait_drained();

      // ---- smallest framebuffer: single tile, most boxes culled ----
      set_framebuffer(1, 1);
      queue_triangle(0, 0, PX-1, PX-1, 0, PX-1);
      queue_triangle(PX, 0, PX+5, 0, PX, 3);
      queue_random(30);
      wait_drained();

      // ---- zero width, then zero height: everything culled ----
      set_framebuffer(0, FB_RESET);
      queue_triangle(10*PX, 10*PX, 20*PX, 10*PX, 10*PX, 20*PX);
      queue_random(8);
      wait_drained();
      set_framebuffer(FB_RESET, 0);
      queue_triangle(10*PX, 10*PX, 20*PX, 10*PX, 10*PX, 20*PX);
      queue_random(8);
      wait_drained();

      // ---- width not a tile multiple, no idling on either side ----
      src_idle_odds = 0;
      snk_idle_odds = 0;
      set_framebuffer(200, 300);
      queue_triangle(190*PX, 120*PX, 220*PX, 135*PX, 195*PX, 125*PX);
      queue_random(60);
      wait_drained();

      // ---- random sizes and random idling mix ----
      repeat (3) begin
         src_idle_odds = $urandom_range(0, 40);
         snk_idle_odds = $urandom_range(0, 40);
         set_framebuffer($urandom_range(1, SIZE_MASK), $urandom_range(1, SIZE_MASK));
         queue_random(50);
         wait_drained();
      end

      // ---- last stretch at full rate ----
      src_idle_odds = 0;
      snk_idle_odds = 0;
      set_framebuffer(FB_RESET, 768);
      queue_random(60);
      wait_drained();

      if (mismatch_count == 0) begin
         $display("** triangle_tile_binning_unit: PASSED **");
      end else begin
         $display("** triangle_tile_binning_unit: FAILED **");
      end
      $finish;
   end

endmodule

// ----- files.f -----
rtl/tbin_pkg.sv
rtl/tbin_req_if.sv
rtl/tbin_rsp_if.sv
rtl/tbin_front.sv
rtl/tbin_queue.sv
rtl/tbin_back.sv
rtl/triangle_tile_binning_unit.sv
tb/triangle_tile_binning_unit_tb.sv
